@@ src/track_row_stream_encoder_unit_assert.svh @@
// Assertion macros for the track row stream encoder.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef TRACK_ROW_STREAM_ENCODER_UNIT_ASSERT_SVH
`define TRACK_ROW_STREAM_ENCODER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define TRSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication.
`define TRSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TRSE_ASSERT_IMP(lbl, ante, cons, msg)
`define TRSE_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/trse_pkg.sv @@
package trse_pkg;

  localparam int unsigned MaxRowsDef   = 256;
  localparam int unsigned CountBitsDef = 16;

  // Most result bytes one item can cause.
  localparam int unsigned SlotMax = 6;

  // Stream command bytes.
  localparam logic [7:0] PauseCmd = 8'd62;
  localparam logic [7:0] SpeedCmd = 8'd63;
  localparam logic [5:0] VolOnly  = 6'd61;
  localparam logic [7:0] LoopCmd  = 8'h80 | 8'd63;
  localparam logic [7:0] EndCmd   = 8'd255;

  localparam logic [15:0] CapReset = 16'd256;

  // Register indexes, taken from paddr[2].
  localparam logic RegCap = 1'b0;
  localparam logic RegAlt = 1'b1;

  // Input kinds.
  localparam logic ActRow = 1'b0;
  localparam logic ActEnd = 1'b1;

  typedef enum logic [1:0] {
    SLOT_BYTE = 2'd0,  // byte from the slot
    SLOT_LOOP = 2'd1,  // low byte of the recorded loop index
    SLOT_NULL = 2'd2   // result without a write attempt
  } slot_kind_e;

  typedef struct packed {
    slot_kind_e kind;
    logic [7:0] data;
  } slot_t;

  typedef struct packed {
    logic               full_length;
    logic               is_loop_row;
    logic signed [8:0]  speed_value;
    logic signed [4:0]  volume_value;
    logic signed [6:0]  instrument;
    logic signed [6:0]  note_value;
  } in_item_t;

endpackage

@@ src/track_row_stream_encoder_unit.sv @@
// Channel   Dir  Handshake                   Payload
// s_axis    in   s_axis_tvalid/tready        tdata: item fields, tuser: action
// m_axis    out  m_axis_tvalid/tready        tdata: result fields, tuser: flags,
//                                            tlast: last_of_run
// apb       in   psel/penable/pwrite, pready config: out_capacity, alt_end_mode
//
// One result leaves per cycle unless m_axis_tready stalls it; the single byte
// emitter shifts each item's slot list out into the output register. The next
// item is decoded in the cycle its predecessor issues its last result.
// Reset restores out_capacity 256, alt_end_mode 0 and clears the track state.
// m_axis_tready low holds the output register and the emitter; the input
// register then fills and s_axis_tready drops.
module track_row_stream_encoder_unit
  import trse_pkg::*;
#(
  parameter int unsigned MAX_ROWS   = MaxRowsDef,
  parameter int unsigned COUNT_BITS = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // note_value[6:0], instrument[13:7], volume_value[18:14], speed_value[27:19],
  // is_loop_row[28], full_length[29], zero[31:30]
  input  logic [31:0] s_axis_tdata,
  // action[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // out_byte[7:0], byte_index[23:8], overflow[24], total_bytes[40:25], zero[47:41]
  output logic [47:0] m_axis_tdata,
  // byte_valid[0], track_done[1]
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned PauseW = $clog2(MAX_ROWS + 1);
  localparam int unsigned SlotW  = $bits(slot_t);
  localparam int unsigned CntW   = $clog2(SlotMax + 1);

  // Configuration
  logic [15:0] cap_q;
  logic        alt_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
      alt_q <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        RegCap:  cap_q <= pwdata[15:0];
        RegAlt:  alt_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      RegCap:  prdata = {16'd0, cap_q};
      RegAlt:  prdata = {31'd0, alt_q};
      default: prdata = '0;
    endcase
  end

  // Input register
  logic     in_valid_q;
  in_item_t in_q;
  logic     act_q;
  logic     decode;

  assign s_axis_tready = !in_valid_q || decode;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid_q <= 1'b1;
    end else if (decode) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q  <= in_item_t'(s_axis_tdata[29:0]);
      act_q <= s_axis_tuser;
    end
  end

  // Track state
  logic [PauseW-1:0]     pause_q, pause_d;
  logic                  loop_seen_q, loop_seen_d;
  logic [COUNT_BITS-1:0] wc_q, wc_d, wc_post;
  logic [COUNT_BITS-1:0] loop_idx_q, loop_idx_d;
  logic                  ovf_q, ovf_d;

  // Pending pause as stream bytes
  logic [8:0] p9;
  logic [1:0] pause_n;
  logic [7:0] pb0, pb1;

  assign p9      = 9'(pause_q);
  assign pause_n = (p9 == 9'd0) ? 2'd0 : ((p9 <= 9'd3) ? 2'd1 : 2'd2);
  assign pb0     = (p9 <= 9'd3) ? (PauseCmd | 8'(p9 << 6)) : PauseCmd;
  assign pb1     = p9[7:0];

  // Decode one item into its slot list
  logic                  has_note, has_instr, has_vol, has_speed, trig;
  logic [3:0]            vol;
  slot_t [SlotMax-1:0]   dec_slots;
  logic [CntW-1:0]       dec_cnt;
  logic                  dec_cap_en;
  logic [CntW-1:0]       dec_cap_pos;
  logic [PauseW-1:0]     dec_pause;
  logic                  dec_loop_seen;

  assign has_note  = !in_q.note_value[6];
  assign has_instr = !in_q.instrument[6];
  assign has_vol   = !in_q.volume_value[4];
  assign has_speed = !in_q.speed_value[8];
  assign trig      = has_vol || has_speed || in_q.is_loop_row;
  assign vol       = in_q.volume_value[3:0];

  always_comb begin
    dec_slots     = '0;
    dec_cnt       = '0;
    dec_cap_en    = 1'b0;
    dec_cap_pos   = '0;
    dec_pause     = pause_q;
    dec_loop_seen = loop_seen_q;
    if (act_q == ActRow) begin
      if (trig) begin
        dec_slots[0] = '{kind: SLOT_BYTE, data: pb0};
        dec_slots[1] = '{kind: SLOT_BYTE, data: pb1};
        dec_cnt      = CntW'(pause_n);
        dec_pause    = '0;
      end
      if (in_q.is_loop_row) begin
        dec_cap_en    = 1'b1;
        dec_cap_pos   = dec_cnt;
        dec_loop_seen = 1'b1;
      end
      if (has_speed) begin
        dec_slots[dec_cnt]         = '{kind: SLOT_BYTE, data: SpeedCmd};
        dec_slots[dec_cnt + 1'b1]  = '{kind: SLOT_BYTE, data: in_q.speed_value[7:0]};
        dec_cnt                    = dec_cnt + CntW'(2);
      end
      if (has_note && has_instr && has_vol) begin
        dec_slots[dec_cnt]        = '{kind: SLOT_BYTE,
                                      data: {vol[1:0], in_q.note_value[5:0]}};
        dec_slots[dec_cnt + 1'b1] = '{kind: SLOT_BYTE,
                                      data: {in_q.instrument[5:0], vol[3:2]}};
        dec_cnt                   = dec_cnt + CntW'(2);
        dec_pause                 = '0;
      end else if (has_vol) begin
        dec_slots[dec_cnt]        = '{kind: SLOT_BYTE, data: {vol[1:0], VolOnly}};
        dec_slots[dec_cnt + 1'b1] = '{kind: SLOT_BYTE, data: {6'd0, vol[3:2]}};
        dec_cnt                   = dec_cnt + CntW'(2);
        dec_pause                 = '0;
      end else if (dec_pause < PauseW'(MAX_ROWS)) begin
        dec_pause = dec_pause + 1'b1;
      end
    end else begin
      // Flush the pause unless the alternate mode skips it
      if (!alt_q || (!in_q.full_length && loop_seen_q)) begin
        dec_slots[0] = '{kind: SLOT_BYTE, data: pb0};
        dec_slots[1] = '{kind: SLOT_BYTE, data: pb1};
        dec_cnt      = CntW'(pause_n);
      end
      if (!in_q.full_length) begin
        if (loop_seen_q) begin
          dec_slots[dec_cnt]        = '{kind: SLOT_BYTE, data: LoopCmd};
          dec_slots[dec_cnt + 1'b1] = '{kind: SLOT_LOOP, data: 8'd0};
          dec_cnt                   = dec_cnt + CntW'(2);
        end else begin
          dec_slots[dec_cnt] = '{kind: SLOT_BYTE, data: EndCmd};
          dec_cnt            = dec_cnt + 1'b1;
        end
      end else if (alt_q && (pause_n != 2'd0)) begin
        dec_slots[0] = '{kind: SLOT_BYTE, data: EndCmd};
        dec_cnt      = CntW'(1);
      end
      if (dec_cnt == '0) begin
        dec_slots[0] = '{kind: SLOT_NULL, data: 8'd0};
        dec_cnt      = CntW'(1);
      end
      dec_pause     = '0;
      dec_loop_seen = 1'b0;
    end
  end

  // Byte emitter
  slot_t [SlotMax-1:0] slots_q;
  logic [CntW-1:0]     n_q;
  logic                is_end_q;
  logic                cap_en_q;
  logic [CntW-1:0]     cap_cnt_q;
  logic                m_valid_q;
  logic                issue, last, ok, attempt, done;
  slot_t               head;

  assign head    = slots_q[0];
  assign issue   = (n_q != '0) && (!m_valid_q || m_axis_tready);
  assign last    = (n_q == CntW'(1));
  assign decode  = in_valid_q && ((n_q == '0) || (issue && last));
  assign attempt = (head.kind != SLOT_NULL);
  assign ok      = attempt && !ovf_q && (16'(wc_q) < cap_q) && (wc_q != '1);
  assign done    = last && is_end_q;
  assign wc_post = ok ? (wc_q + 1'b1) : wc_q;

  always_comb begin
    wc_d       = wc_q;
    ovf_d      = ovf_q;
    loop_idx_d = loop_idx_q;
    if (issue) begin
      wc_d  = wc_post;
      ovf_d = ovf_q || (attempt && !ok);
      if (cap_en_q && (cap_cnt_q == CntW'(1))) begin
        loop_idx_d = wc_post;
      end
      if (done) begin
        wc_d       = '0;
        ovf_d      = 1'b0;
        loop_idx_d = '0;
      end
    end
    // A loop row with no pause to flush records the count right away
    if (decode && dec_cap_en && (dec_cap_pos == '0)) begin
      loop_idx_d = wc_d;
    end
  end

  assign pause_d     = decode ? dec_pause : pause_q;
  assign loop_seen_d = decode ? dec_loop_seen : loop_seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pause_q     <= '0;
      loop_seen_q <= 1'b0;
      wc_q        <= '0;
      loop_idx_q  <= '0;
      ovf_q       <= 1'b0;
      n_q         <= '0;
      is_end_q    <= 1'b0;
      cap_en_q    <= 1'b0;
      cap_cnt_q   <= '0;
    end else begin
      pause_q     <= pause_d;
      loop_seen_q <= loop_seen_d;
      wc_q        <= wc_d;
      loop_idx_q  <= loop_idx_d;
      ovf_q       <= ovf_d;
      if (decode) begin
        n_q       <= dec_cnt;
        is_end_q  <= (act_q == ActEnd);
        cap_en_q  <= dec_cap_en && (dec_cap_pos != '0);
        cap_cnt_q <= dec_cap_pos;
      end else if (issue) begin
        n_q       <= n_q - 1'b1;
        cap_cnt_q <= cap_cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (decode) begin
      slots_q <= dec_slots;
    end else if (issue) begin
      slots_q <= slots_q >> SlotW;
    end
  end

  // Output register
  logic [7:0]  out_byte_q;
  logic        out_bvld_q;
  logic [15:0] out_idx_q;
  logic        out_last_q;
  logic        out_done_q;
  logic        out_ovf_q;
  logic [15:0] out_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (issue) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      out_byte_q  <= ok ? ((head.kind == SLOT_LOOP) ? loop_idx_q[7:0] : head.data) : 8'd0;
      out_bvld_q  <= ok;
      out_idx_q   <= 16'(wc_q);
      out_last_q  <= last;
      out_done_q  <= done;
      out_ovf_q   <= ovf_q || (attempt && !ok);
      out_total_q <= done ? 16'(wc_post) : 16'd0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = {out_done_q, out_bvld_q};
  assign m_axis_tdata  = {7'd0, out_total_q, out_ovf_q, out_idx_q, out_byte_q};

`include "track_row_stream_encoder_unit_assert.svh"

  `TRSE_ASSERT_IMP(a_done_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast, "done not last")
  `TRSE_ASSERT_IMP(a_ovf_store, m_axis_tvalid && m_axis_tuser[0], !m_axis_tdata[24], "bad ovf")
  `TRSE_ASSERT_NXT(a_end_clears, issue && done, (wc_q == '0) && !ovf_q, "end did not clear")

endmodule

@@ tb/sv/trse_stream_checker.sv @@
module trse_stream_checker
  import trse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // note_value[6:0], instrument[13:7], volume_value[18:14], speed_value[27:19],
  // is_loop_row[28], full_length[29], zero[31:30]
  input  logic [31:0] s_axis_tdata,
  // action[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // out_byte[7:0], byte_index[23:8], overflow[24], total_bytes[40:25], zero[47:41]
  input  logic [47:0] m_axis_tdata,
  // byte_valid[0], track_done[1]
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o,
  output int          results_o,
  output int          tracks_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [15:0] CountLimit = 16'((32'd1 << CountBitsDef) - 1);
  localparam int MaxReports = 40;

  typedef struct packed {
    logic [7:0]  data;
    logic        valid;
    logic [15:0] index;
    logic        last;
    logic        done;
    logic        ovf;
    logic [15:0] total;
  } stream_byte_t;

  stream_byte_t expected_bytes[$];
  stream_byte_t item_bytes[$];

  logic [15:0] cfg_cap = CapReset;
  logic        cfg_alt = 1'b0;

  logic [8:0]  pause_cnt = '0;
  logic [15:0] wr_cnt = '0;
  logic [15:0] loop_idx = '0;
  logic        loop_flag = 1'b0;
  logic        ovf_flag = 1'b0;

  initial begin
    fail_count_o = 0;
    pending_o = 0;
    results_o = 0;
    tracks_o = 0;
  end

  task automatic clear_track();
    pause_cnt = '0;
    wr_cnt = '0;
    loop_idx = '0;
    loop_flag = 1'b0;
    ovf_flag = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    fail_count_o++;
    if (fail_count_o <= MaxReports)
      $display("%0t: %s mismatch on result %0d: got %0h, expected %0h",
               $time, what, results_o, got, want);
  endtask

  // A refused write still yields a result, with byte_valid low.
  task automatic put_byte(input logic [7:0] b);
    stream_byte_t r;
    if (item_bytes.size() < SlotMax) begin
      r = '0;
      r.index = wr_cnt;
      if (!ovf_flag && wr_cnt < cfg_cap && wr_cnt < CountLimit) begin
        r.data = b;
        r.valid = 1'b1;
        wr_cnt = wr_cnt + 16'd1;
      end else begin
        ovf_flag = 1'b1;
      end
      r.ovf = ovf_flag;
      item_bytes.push_back(r);
    end
  endtask

  task automatic flush_pause();
    if (pause_cnt != '0) begin
      if (pause_cnt <= 9'd3) begin
        put_byte(PauseCmd | {pause_cnt[1:0], 6'b0});
      end else begin
        put_byte(PauseCmd);
        put_byte(pause_cnt[7:0]);
      end
      pause_cnt = '0;
    end
  endtask

  task automatic encode_item(input logic act, input in_item_t it);
    stream_byte_t r;
    logic has_note, has_ins, has_vol, has_spd;
    item_bytes.delete();
    has_note = !it.note_value[6];
    has_ins  = !it.instrument[6];
    has_vol  = !it.volume_value[4];
    has_spd  = !it.speed_value[8];
    if (act == ActRow) begin
      if (has_vol || has_spd || it.is_loop_row) begin
        flush_pause();
        if (it.is_loop_row) begin
          loop_idx = wr_cnt;
          loop_flag = 1'b1;
        end
        if (has_spd) begin
          put_byte(SpeedCmd);
          put_byte(it.speed_value[7:0]);
        end
      end
      if (has_note && has_ins && has_vol) begin
        put_byte({it.volume_value[1:0], it.note_value[5:0]});
        put_byte({it.instrument[5:0], it.volume_value[3:2]});
        pause_cnt = '0;
      end else if (has_vol) begin
        put_byte({it.volume_value[1:0], VolOnly});
        put_byte({6'd0, it.volume_value[3:2]});
        pause_cnt = '0;
      end else if (pause_cnt < 9'(MaxRowsDef)) begin
        pause_cnt = pause_cnt + 9'd1;
      end
      if (item_bytes.size() > 0) begin
        r = item_bytes.pop_back();
        r.last = 1'b1;
        item_bytes.push_back(r);
      end
    end else begin
      if (!cfg_alt) begin
        flush_pause();
        if (!it.full_length) begin
          if (loop_flag) begin
            put_byte(LoopCmd);
            put_byte(loop_idx[7:0]);
          end else begin
            put_byte(EndCmd);
          end
        end
      end else if (!it.full_length) begin
        if (loop_flag) begin
          flush_pause();
          put_byte(LoopCmd);
          put_byte(loop_idx[7:0]);
        end else begin
          put_byte(EndCmd);
        end
      end else if (pause_cnt != '0) begin
        put_byte(EndCmd);
      end
      // An end that writes nothing still closes the track with one result.
      if (item_bytes.size() == 0) begin
        r = '0;
        r.index = wr_cnt;
        r.ovf = ovf_flag;
      end else begin
        r = item_bytes.pop_back();
      end
      r.last = 1'b1;
      r.done = 1'b1;
      r.total = wr_cnt;
      item_bytes.push_back(r);
      clear_track();
    end
    foreach (item_bytes[k]) expected_bytes.push_back(item_bytes[k]);
  endtask

  task automatic check_result();
    stream_byte_t want;
    if (expected_bytes.size() == 0) begin
      report_mismatch("unexpected transfer", 1, 0);
    end else begin
      want = expected_bytes.pop_front();
      if (m_axis_tdata[7:0] != want.data)
        report_mismatch("out_byte", m_axis_tdata[7:0], want.data);
      if (m_axis_tuser[0] != want.valid)
        report_mismatch("byte_valid", m_axis_tuser[0], want.valid);
      if (m_axis_tdata[23:8] != want.index)
        report_mismatch("byte_index", m_axis_tdata[23:8], want.index);
      if (m_axis_tlast != want.last)
        report_mismatch("last_of_run", m_axis_tlast, want.last);
      if (m_axis_tuser[1] != want.done)
        report_mismatch("track_done", m_axis_tuser[1], want.done);
      if (m_axis_tdata[24] != want.ovf)
        report_mismatch("overflow", m_axis_tdata[24], want.ovf);
      if (m_axis_tdata[40:25] != want.total)
        report_mismatch("total_bytes", m_axis_tdata[40:25], want.total);
    end
    results_o++;
    if (m_axis_tuser[1]) tracks_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_track();
      cfg_cap = CapReset;
      cfg_alt = 1'b0;
      expected_bytes.delete();
    end else begin
      // Compare outgoing transfers before queueing the results of a new item.
      if (m_axis_tvalid && m_axis_tready) check_result();
      if (s_axis_tvalid && s_axis_tready)
        encode_item(s_axis_tuser, in_item_t'(s_axis_tdata[29:0]));
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == RegCap) cfg_cap = pwdata[15:0];
        else cfg_alt = pwdata[0];
      end
    end
    pending_o = expected_bytes.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import trse_pkg::*;

  localparam int HoldCycles   = 200;
  localparam int SettleCycles = 16;
  localparam int PhaseItems   = 22;
  localparam int NumPhases    = 5;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic [31:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count, pending, results_seen, tracks_seen;
  int items_sent = 0;
  int configs_used = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  bit hold_req = 1'b0;

  always #6 clk_i = ~clk_i;

  track_row_stream_encoder_unit dut (.*);

  trse_stream_checker u_checker (
    .*,
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results_seen),
    .tracks_o     (tracks_seen)
  );

  function automatic logic [8:0] pick_field(int unsigned w, int unsigned absent_pct);
    logic [8:0] v;
    v = 9'($urandom);
    v[w-1] = ($urandom_range(99) < absent_pct);
    return v & 9'((1 << w) - 1);
  endfunction

  function automatic in_item_t mk_row(int note, int ins, int vol, int spd, bit loop_row);
    in_item_t it;
    it = '0;
    it.note_value   = 7'(note);
    it.instrument   = 7'(ins);
    it.volume_value = 5'(vol);
    it.speed_value  = 9'(spd);
    it.is_loop_row  = loop_row;
    return it;
  endfunction

  // Unused fields of an end item carry random bits.
  function automatic in_item_t mk_end(bit full);
    in_item_t it;
    it = in_item_t'(30'($urandom));
    it.full_length = full;
    return it;
  endfunction

  function automatic in_item_t rand_row(int unsigned vol_absent, int unsigned spd_absent,
                                        bit loop_row);
    in_item_t it;
    it.note_value   = 7'(pick_field(7, 25));
    it.instrument   = 7'(pick_field(7, 25));
    it.volume_value = 5'(pick_field(5, vol_absent));
    it.speed_value  = 9'(pick_field(9, spd_absent));
    it.is_loop_row  = loop_row;
    it.full_length  = 1'($urandom_range(1));
    return it;
  endfunction

  task automatic send_item(input logic act, input in_item_t it);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {2'b00, it};
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    if (tx_idle_on && $urandom_range(99) < 12) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18) - 1) @(negedge clk_i);
    end
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Stop offering, wait out every expected transfer, then let rows with no
  // result clear the pipeline.
  task automatic drain();
    int guard;
    guard = 0;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0 && guard < 200000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic configure(input logic [15:0] cap, input logic alt);
    drain();
    apb_write(RegCap, {16'd0, cap});
    apb_write(RegAlt, {31'd0, alt});
    configs_used++;
  endtask

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (rx_idle_on && $urandom_range(99) < 10) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    logic [15:0] phase_cap [NumPhases];
    logic        phase_alt [NumPhases];
    int n, len, r;
    bit held;
    rst_ni = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    s_axis_tvalid = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    held = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at reset settings: standard end, capacity 256.
    send_item(ActRow, mk_row(0, 0, 0, -1, 0));
    send_item(ActRow, mk_row(63, 63, 15, 255, 1));
    send_item(ActRow, mk_row(-64, -64, -16, -256, 0));
    send_item(ActRow, mk_row(7, -1, 9, -1, 0));      // note without instrument
    repeat (3) send_item(ActRow, mk_row(-1, -1, -1, -1, 0));
    send_item(ActRow, mk_row(-1, -1, -1, 0, 0));     // short pause, then speed
    repeat (4) send_item(ActRow, mk_row(-1, -1, -1, -1, 0));
    send_item(ActRow, mk_row(-1, -1, -1, -1, 1));    // long pause flushed by loop mark
    send_item(ActRow, mk_row(12, 5, -1, -1, 0));     // note without volume counts as pause
    send_item(ActEnd, mk_end(0));
    send_item(ActEnd, mk_end(1));                    // end without bytes
    send_item(ActEnd, mk_end(0));

    // Alternate end rules.
    configure(CapReset, 1'b1);
    repeat (2) send_item(ActRow, mk_row(-1, -1, -1, -1, 0));
    send_item(ActEnd, mk_end(1));
    send_item(ActEnd, mk_end(1));
    send_item(ActRow, mk_row(-1, -1, -1, -1, 1));
    send_item(ActEnd, mk_end(0));
    send_item(ActRow, mk_row(-1, -1, -1, -1, 0));
    send_item(ActEnd, mk_end(0));

    // Overflow: tiny capacity, then none at all.
    configure(16'd3, 1'b0);
    repeat (2) send_item(ActRow, mk_row(1, 2, 3, -1, 0));
    send_item(ActRow, mk_row(-1, -1, 4, -1, 0));
    send_item(ActEnd, mk_end(0));
    configure(16'd0, 1'b1);
    send_item(ActRow, mk_row(63, 63, 15, 255, 1));
    send_item(ActEnd, mk_end(0));

    // Pause count saturates at the row limit; its low byte is then zero.
    configure(16'hFFFF, 1'b0);
    repeat (MaxRowsDef + 14) send_item(ActRow, mk_row(-1, -1, -1, -1, 0));
    send_item(ActRow, mk_row(-1, -1, 5, -1, 0));
    send_item(ActEnd, mk_end(1));

    phase_cap[0] = 16'hFFFF;                         phase_alt[0] = 1'b1;
    phase_cap[1] = 16'($urandom_range(4, 40));       phase_alt[1] = 1'b0;
    phase_cap[2] = 16'd0;                            phase_alt[2] = 1'b1;
    phase_cap[3] = 16'($urandom_range(41, 300));     phase_alt[3] = 1'($urandom_range(1));
    phase_cap[4] = CapReset;                         phase_alt[4] = 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == NumPhases - 1) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      configure(phase_cap[ph], phase_alt[ph]);
      n = 0;
      while (n < PhaseItems) begin
        if (!held && n >= 10) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        r = $urandom_range(99);
        if (r < 8) begin
          send_item(1'($urandom_range(1)), in_item_t'(30'($urandom)));
          n++;
        end else if (r < 20) begin
          send_item(ActEnd, mk_end(1'($urandom_range(1))));
          n++;
        end else if (r < 45) begin
          len = $urandom_range(1, 12);
          repeat (len) send_item(ActRow, rand_row(100, 100, 1'b0));
          n += len;
        end else begin
          send_item(ActRow, rand_row(35, 75, $urandom_range(15) == 0));
          n++;
        end
      end
    end

    drain();
    $display("testbench: %0d items in %0d register settings, %0d results, %0d tracks closed",
             items_sent, configs_used, results_seen, tracks_seen);
    $display("testbench: pauses to saturation, loop rows, speeds, both end modes, overflow");
    if (pending != 0)
      $display("testbench: %0d expected results never arrived", pending);
    if (fail_count == 0 && pending == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
